[rtl/core/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Types, constants and arithmetic helpers for the D2Q9 BGK collision kernel.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int VALUE_BITS    = 24;
   localparam int FRACTION_BITS = 20;
   localparam int OMEGA_BITS    = 22;
   localparam int OMEGA_FRAC    = 20;
   localparam int DIRS          = 9;

   localparam int DIV_STEPS = VALUE_BITS + FRACTION_BITS;
   localparam int SQ_BITS   = 2 * VALUE_BITS - FRACTION_BITS + 1;
   localparam int TERM_BITS = VALUE_BITS + 5;
   localparam int PROD_BITS = OMEGA_BITS + VALUE_BITS + 2;

   localparam logic [OMEGA_BITS-1:0] OMEGA_RESET = OMEGA_BITS'(1 << OMEGA_FRAC);

   localparam int DIR_REST = 0;
   localparam int DIR_E    = 1;
   localparam int DIR_N    = 2;
   localparam int DIR_W    = 3;
   localparam int DIR_S    = 4;
   localparam int DIR_NE   = 5;
   localparam int DIR_NW   = 6;
   localparam int DIR_SW   = 7;
   localparam int DIR_SE   = 8;

   // half weights, round to nearest
   localparam longint HW_REST = ((longint'(2) << (FRACTION_BITS + 1)) + 9) / 18;
   localparam longint HW_AXIS = ((longint'(1) << (FRACTION_BITS + 1)) + 18) / 36;
   localparam longint HW_DIAG = ((longint'(1) << (FRACTION_BITS + 1)) + 72) / 144;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< (VALUE_BITS - 1));
   localparam logic signed [63:0] TWO_ONE = 64'sd2 <<< FRACTION_BITS;

   typedef logic signed [VALUE_BITS-1:0] val_type;

   typedef struct packed {
      val_type f_rest;
      val_type f_east;
      val_type f_north;
      val_type f_west;
      val_type f_south;
      val_type f_northeast;
      val_type f_northwest;
      val_type f_southwest;
      val_type f_southeast;
   } req_type;

   typedef struct packed {
      val_type g_rest;
      val_type g_east;
      val_type g_north;
      val_type g_west;
      val_type g_south;
      val_type g_northeast;
      val_type g_northwest;
      val_type g_southwest;
      val_type g_southeast;
      val_type node_density;
      val_type velocity_x;
      val_type velocity_y;
   } rsp_type;

   typedef struct packed {
      val_type [DIRS-1:0] f;
      val_type            rho;
      val_type            mx;
      val_type            my;
   } sums_type;

   typedef struct packed {
      val_type [DIRS-1:0]    f;
      val_type               rho;
      logic [DIV_STEPS-1:0]  nq_x;
      logic [DIV_STEPS-1:0]  nq_y;
      logic [VALUE_BITS-1:0] rem_x;
      logic [VALUE_BITS-1:0] rem_y;
      logic [VALUE_BITS-1:0] den;
      logic                  neg_x;
      logic                  neg_y;
   } div_type;

   typedef struct packed {
      val_type [DIRS-1:0]                     f;
      val_type                                rho;
      val_type                                ux;
      val_type                                uy;
      val_type [2:0]                          wr;
      val_type [DIRS-1:0]                     cu;
      logic signed [DIRS-1:0][SQ_BITS-1:0]    sq;
      logic signed [DIRS-1:0][TERM_BITS-1:0]  term;
      val_type [DIRS-1:0]                     feq;
      logic signed [DIRS-1:0][PROD_BITS-1:0]  prod;
      val_type [DIRS-1:0]                     g;
   } work_type;

   // shift right with round half away from zero
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p,
                                                  input int unsigned s);
      logic [63:0] m;
      logic [63:0] r;
      m = p[63] ? 64'(-p) : 64'(p);
      r = (m + (64'd1 << (s - 1))) >> s;
      rnd_shr = p[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic val_type sat_v(input logic signed [63:0] x);
      logic signed [63:0] y;
      if (x > SAT_HI) y = SAT_HI;
      else if (x < SAT_LO) y = SAT_LO;
      else y = x;
      sat_v = y[VALUE_BITS-1:0];
   endfunction

   function automatic int unsigned dir_class(input int q);
      if (q == DIR_REST) dir_class = 0;
      else if (q <= DIR_S) dir_class = 1;
      else dir_class = 2;
   endfunction

endpackage

[rtl/core/lattice_boltzmann_collision.sv]
// Divider: the velocity is formed by a restoring divider, one quotient bit per stage.
// Throughput: one node per cycle while rsp_stall is low; stages advance independently,
//   so bubbles are squeezed out while rsp_stall is high.
// Reset: synchronous, clears all stage valids; relaxation rate returns to 1.0.
// ----------------------------------------------------------------------------
// lattice_boltzmann_collision
// D2Q9 BGK collision of one lattice node per beat, signed Q3.20 fixed point.
// ----------------------------------------------------------------------------
module lattice_boltzmann_collision (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lbc_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lbc_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_wr_en,
   input  logic [lbc_pkg::OMEGA_BITS-1:0]         csr_wr_data
);

   localparam int V      = lbc_pkg::VALUE_BITS;
   localparam int F      = lbc_pkg::FRACTION_BITS;
   localparam int D      = lbc_pkg::DIV_STEPS;
   localparam int NQ     = lbc_pkg::DIRS;
   localparam int NPD    = 7;
   localparam int DV0    = 2;
   localparam int PD0    = D + 3;
   localparam int NSTAGE = D + 10;

   logic [NSTAGE-1:0]              vld_ff;
   logic [NSTAGE:0]                rdy;
   logic [lbc_pkg::OMEGA_BITS-1:0] omega_ff;

   lbc_pkg::req_type  s0_ff;
   lbc_pkg::sums_type s1_ff, s1_in;
   lbc_pkg::div_type  dv_ff [0:D];
   lbc_pkg::div_type  dv_in [0:D];
   lbc_pkg::work_type pd_ff [0:NPD-1];
   lbc_pkg::work_type pd_in [0:NPD-1];

   // ---- handshake ----
   always_comb begin
      rdy[NSTAGE] = !rsp_stall;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         omega_ff <= lbc_pkg::OMEGA_RESET;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (csr_wr_en) begin
            omega_ff <= csr_wr_data;
         end
      end
   end

   // ---- sums ----
   always_comb begin
      s1_in.f[lbc_pkg::DIR_REST] = s0_ff.f_rest;
      s1_in.f[lbc_pkg::DIR_E]    = s0_ff.f_east;
      s1_in.f[lbc_pkg::DIR_N]    = s0_ff.f_north;
      s1_in.f[lbc_pkg::DIR_W]    = s0_ff.f_west;
      s1_in.f[lbc_pkg::DIR_S]    = s0_ff.f_south;
      s1_in.f[lbc_pkg::DIR_NE]   = s0_ff.f_northeast;
      s1_in.f[lbc_pkg::DIR_NW]   = s0_ff.f_northwest;
      s1_in.f[lbc_pkg::DIR_SW]   = s0_ff.f_southwest;
      s1_in.f[lbc_pkg::DIR_SE]   = s0_ff.f_southeast;
      s1_in.rho = lbc_pkg::sat_v(64'(s0_ff.f_rest) + 64'(s0_ff.f_east) + 64'(s0_ff.f_north)
                  + 64'(s0_ff.f_west) + 64'(s0_ff.f_south) + 64'(s0_ff.f_northeast)
                  + 64'(s0_ff.f_northwest) + 64'(s0_ff.f_southwest)
                  + 64'(s0_ff.f_southeast));
      s1_in.mx  = lbc_pkg::sat_v(64'(s0_ff.f_east) - 64'(s0_ff.f_west)
                  + 64'(s0_ff.f_northeast) - 64'(s0_ff.f_northwest)
                  - 64'(s0_ff.f_southwest) + 64'(s0_ff.f_southeast));
      s1_in.my  = lbc_pkg::sat_v(64'(s0_ff.f_north) - 64'(s0_ff.f_south)
                  + 64'(s0_ff.f_northeast) + 64'(s0_ff.f_northwest)
                  - 64'(s0_ff.f_southwest) - 64'(s0_ff.f_southeast));
   end

   // ---- divider: one quotient bit per stage ----
   always_comb begin
      logic [V:0] rx;
      logic [V:0] ry;
      dv_in[0].f     = s1_ff.f;
      dv_in[0].rho   = s1_ff.rho;
      dv_in[0].neg_x = s1_ff.mx[V-1] ^ s1_ff.rho[V-1];
      dv_in[0].neg_y = s1_ff.my[V-1] ^ s1_ff.rho[V-1];
      dv_in[0].den   = s1_ff.rho[V-1] ? V'(-s1_ff.rho) : V'(s1_ff.rho);
      dv_in[0].nq_x  = {(s1_ff.mx[V-1] ? V'(-s1_ff.mx) : V'(s1_ff.mx)), F'(0)};
      dv_in[0].nq_y  = {(s1_ff.my[V-1] ? V'(-s1_ff.my) : V'(s1_ff.my)), F'(0)};
      dv_in[0].rem_x = '0;
      dv_in[0].rem_y = '0;
      for (int k = 0; k < D; k++) begin
         dv_in[k+1] = dv_ff[k];
         rx = {dv_ff[k].rem_x, dv_ff[k].nq_x[D-1]};
         ry = {dv_ff[k].rem_y, dv_ff[k].nq_y[D-1]};
         if (rx >= {1'b0, dv_ff[k].den}) begin
            rx = rx - {1'b0, dv_ff[k].den};
            dv_in[k+1].nq_x = {dv_ff[k].nq_x[D-2:0], 1'b1};
         end else begin
            dv_in[k+1].nq_x = {dv_ff[k].nq_x[D-2:0], 1'b0};
         end
         if (ry >= {1'b0, dv_ff[k].den}) begin
            ry = ry - {1'b0, dv_ff[k].den};
            dv_in[k+1].nq_y = {dv_ff[k].nq_y[D-2:0], 1'b1};
         end else begin
            dv_in[k+1].nq_y = {dv_ff[k].nq_y[D-2:0], 1'b0};
         end
         dv_in[k+1].rem_x = rx[V-1:0];
         dv_in[k+1].rem_y = ry[V-1:0];
      end
   end

   function automatic lbc_pkg::val_type div_done(input logic [D-1:0] q, input logic neg,
                                                 input logic nz);
      logic [D-1:0] cap;
      cap = D'(1) << (V - 1);
      if (!nz) div_done = '0;
      else if (q >= cap) div_done = neg ? lbc_pkg::SAT_LO[V-1:0] : lbc_pkg::SAT_HI[V-1:0];
      else div_done = neg ? -$signed(q[V-1:0]) : $signed(q[V-1:0]);
   endfunction

   // ---- equilibrium and relaxation ----
   always_comb begin
      logic                    nz;
      logic signed [V+F:0]     wp;
      logic signed [2*V-1:0]   sp;
      logic signed [63:0]      uu;
      logic signed [63:0]      c2;
      logic signed [V+lbc_pkg::TERM_BITS-1:0] fp;
      logic signed [V:0]       df;
      logic [F-1:0]            hw [0:2];
      logic signed [63:0]      r;

      hw[0] = F'(lbc_pkg::HW_REST);
      hw[1] = F'(lbc_pkg::HW_AXIS);
      hw[2] = F'(lbc_pkg::HW_DIAG);

      // velocity and weighted density
      pd_in[0]     = pd_ff[0];
      pd_in[0].f   = dv_ff[D].f;
      pd_in[0].rho = dv_ff[D].rho;
      nz           = dv_ff[D].rho != '0;
      pd_in[0].ux  = div_done(dv_ff[D].nq_x, dv_ff[D].neg_x, nz);
      pd_in[0].uy  = div_done(dv_ff[D].nq_y, dv_ff[D].neg_y, nz);
      for (int c = 0; c < 3; c++) begin
         wp = $signed({1'b0, hw[c]}) * dv_ff[D].rho;
         r  = lbc_pkg::rnd_shr(64'(wp), F);
         pd_in[0].wr[c] = r[V-1:0];
      end

      // c.u per direction
      pd_in[1] = pd_ff[0];
      pd_in[1].cu[lbc_pkg::DIR_REST] = '0;
      pd_in[1].cu[lbc_pkg::DIR_E]  = pd_ff[0].ux;
      pd_in[1].cu[lbc_pkg::DIR_N]  = pd_ff[0].uy;
      pd_in[1].cu[lbc_pkg::DIR_W]  = lbc_pkg::sat_v(-64'(pd_ff[0].ux));
      pd_in[1].cu[lbc_pkg::DIR_S]  = lbc_pkg::sat_v(-64'(pd_ff[0].uy));
      pd_in[1].cu[lbc_pkg::DIR_NE] = lbc_pkg::sat_v(64'(pd_ff[0].ux) + 64'(pd_ff[0].uy));
      pd_in[1].cu[lbc_pkg::DIR_NW] = lbc_pkg::sat_v(64'(pd_ff[0].uy) - 64'(pd_ff[0].ux));
      pd_in[1].cu[lbc_pkg::DIR_SW] = lbc_pkg::sat_v(-64'(pd_ff[0].ux) - 64'(pd_ff[0].uy));
      pd_in[1].cu[lbc_pkg::DIR_SE] = lbc_pkg::sat_v(64'(pd_ff[0].ux) - 64'(pd_ff[0].uy));

      // squares
      pd_in[2] = pd_ff[1];
      for (int q = 0; q < NQ; q++) begin
         sp = pd_ff[1].cu[q] * pd_ff[1].cu[q];
         r  = lbc_pkg::rnd_shr(64'(sp), F);
         pd_in[2].sq[q] = r[lbc_pkg::SQ_BITS-1:0];
      end

      // 2 + 6 cu + 9 cu^2 - 3 u.u
      pd_in[3] = pd_ff[2];
      uu = 64'(lbc_pkg::sat_v(64'($signed(pd_ff[2].sq[lbc_pkg::DIR_E]))
           + 64'($signed(pd_ff[2].sq[lbc_pkg::DIR_N]))));
      for (int q = 0; q < NQ; q++) begin
         c2 = 64'(lbc_pkg::sat_v(64'($signed(pd_ff[2].sq[q]))));
         r  = lbc_pkg::TWO_ONE + 64'sd6 * 64'(pd_ff[2].cu[q]) + 64'sd9 * c2 - 64'sd3 * uu;
         pd_in[3].term[q] = r[lbc_pkg::TERM_BITS-1:0];
      end

      // feq
      pd_in[4] = pd_ff[3];
      for (int q = 0; q < NQ; q++) begin
         fp = pd_ff[3].wr[lbc_pkg::dir_class(q)] * $signed(pd_ff[3].term[q]);
         pd_in[4].feq[q] = lbc_pkg::sat_v(lbc_pkg::rnd_shr(64'(fp), F));
      end

      // omega * (f - feq)
      pd_in[5] = pd_ff[4];
      for (int q = 0; q < NQ; q++) begin
         df = (V+1)'(pd_ff[4].f[q]) - (V+1)'(pd_ff[4].feq[q]);
         pd_in[5].prod[q] = $signed({1'b0, omega_ff}) * df;
      end

      // g = f - omega * (f - feq)
      pd_in[6] = pd_ff[5];
      for (int q = 0; q < NQ; q++) begin
         r = lbc_pkg::rnd_shr(64'($signed(pd_ff[5].prod[q])), lbc_pkg::OMEGA_FRAC);
         pd_in[6].g[q] = lbc_pkg::sat_v(64'(pd_ff[5].f[q]) - r);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s0_ff <= req_data;
      end
      if (rdy[1]) begin
         s1_ff <= s1_in;
      end
      for (int k = 0; k <= D; k++) begin
         if (rdy[DV0+k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      for (int j = 0; j < NPD; j++) begin
         if (rdy[PD0+j]) begin
            pd_ff[j] <= pd_in[j];
         end
      end
   end

   always_comb begin
      rsp_data.g_rest       = pd_ff[NPD-1].g[lbc_pkg::DIR_REST];
      rsp_data.g_east       = pd_ff[NPD-1].g[lbc_pkg::DIR_E];
      rsp_data.g_north      = pd_ff[NPD-1].g[lbc_pkg::DIR_N];
      rsp_data.g_west       = pd_ff[NPD-1].g[lbc_pkg::DIR_W];
      rsp_data.g_south      = pd_ff[NPD-1].g[lbc_pkg::DIR_S];
      rsp_data.g_northeast  = pd_ff[NPD-1].g[lbc_pkg::DIR_NE];
      rsp_data.g_northwest  = pd_ff[NPD-1].g[lbc_pkg::DIR_NW];
      rsp_data.g_southwest  = pd_ff[NPD-1].g[lbc_pkg::DIR_SW];
      rsp_data.g_southeast  = pd_ff[NPD-1].g[lbc_pkg::DIR_SE];
      rsp_data.node_density = pd_ff[NPD-1].rho;
      rsp_data.velocity_x   = pd_ff[NPD-1].ux;
      rsp_data.velocity_y   = pd_ff[NPD-1].uy;
   end

endmodule

[rtl/core/lbc_checker.sv]
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks for the collision kernel, bound to the top level.
// ----------------------------------------------------------------------------
module lbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input lbc_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("req stalled without output backpressure");

   a_zero_density: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.node_density == '0 |->
      rsp_data.velocity_x == '0 && rsp_data.velocity_y == '0)
      else $error("nonzero velocity at zero density");

endmodule

bind lattice_boltzmann_collision lbc_checker u_lbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/tb_lattice_boltzmann_collision.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_boltzmann_collision
// Drives node beats through the D2Q9 BGK collision kernel, predicts each
// result with a behavioral collision model or a stored expected value and checks every result field.
// Directed table first, then random nodes under three idling profiles and
// several relaxation rates, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb_lattice_boltzmann_collision;

   localparam int  LATENCY    = 53;
   localparam int  N_RANDOM   = 1300;
   localparam int  N_DIRECTED = 12;
   localparam int  N_FIELDS   = 12;
   localparam int  VB         = lbc_pkg::VALUE_BITS;
   localparam int  OB         = lbc_pkg::OMEGA_BITS;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [OB-1:0] OMEGA_MAX = OB'(2097152);
   localparam logic [OB-1:0] OMEGA_ALL = '1;

   typedef struct {
      lbc_pkg::req_type  node;
      logic [OB-1:0]     omega;
      bit                has_gold;
      lbc_pkg::rsp_type  gold;
   } dir_row_type;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_wr_en;
   lbc_pkg::req_type req_data;
   lbc_pkg::rsp_type rsp_data;
   logic [OB-1:0] csr_wr_data;

   logic [OB-1:0] omega_model;
   lbc_pkg::rsp_type collided_q[$];
   int  errors = 0;
   longint cycle_count = 0;
   int  src_idle_pct = 0, dst_idle_pct = 0;
   logic hold_on = 1'b0;
   dir_row_type dir_rows[N_DIRECTED];
   string rsp_names[N_FIELDS] = '{"g_rest", "g_east", "g_north", "g_west", "g_south",
                                  "g_northeast", "g_northwest", "g_southwest",
                                  "g_southeast", "node_density", "velocity_x",
                                  "velocity_y"};

   lattice_boltzmann_collision DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_lattice_boltzmann_collision NOT OK");
         $finish;
      end
   end

   function automatic longint sat64(input longint v);
      if (v > lbc_pkg::SAT_HI) return lbc_pkg::SAT_HI;
      if (v < lbc_pkg::SAT_LO) return lbc_pkg::SAT_LO;
      return v;
   endfunction

   // rounded (a*b)>>s, half away from zero, magnitude clamped to 2^62
   function automatic longint round_mul(input longint a, input longint b, input int s);
      logic signed [127:0] p;
      logic [127:0] m;
      p = 128'(a) * 128'(b);
      m = p[127] ? 128'(-p) : 128'(p);
      m = (m + (128'd1 << (s - 1))) >> s;
      if (m > (128'd1 << 62)) m = 128'd1 << 62;
      return p[127] ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint quot_fix(input longint num, input longint den);
      logic [127:0] n, d, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = 128'((num < 0) ? -num : num);
      d = 128'((den < 0) ? -den : den);
      q = (n << lbc_pkg::FRACTION_BITS) / d;
      if (q > 128'(lbc_pkg::SAT_HI) + 1) q = 128'(lbc_pkg::SAT_HI) + 1;
      return sat64(neg ? -longint'(q) : longint'(q));
   endfunction

   function automatic lbc_pkg::rsp_type collide(input lbc_pkg::req_type node,
                                                input logic [OB-1:0] om);
      longint f[lbc_pkg::DIRS];
      longint g[lbc_pkg::DIRS];
      int cx[lbc_pkg::DIRS] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
      int cy[lbc_pkg::DIRS] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
      longint hw[3] = '{lbc_pkg::HW_REST, lbc_pkg::HW_AXIS, lbc_pkg::HW_DIAG};
      longint rho, mx, my, ux, uy, uu, cu, cu2, term, wr, feq;
      lbc_pkg::rsp_type r;
      f[0] = node.f_rest;      f[1] = node.f_east;      f[2] = node.f_north;
      f[3] = node.f_west;      f[4] = node.f_south;     f[5] = node.f_northeast;
      f[6] = node.f_northwest; f[7] = node.f_southwest; f[8] = node.f_southeast;
      rho = 0; mx = 0; my = 0; ux = 0; uy = 0;
      for (int q = 0; q < lbc_pkg::DIRS; q++) begin
         rho += f[q]; mx += f[q] * cx[q]; my += f[q] * cy[q];
      end
      rho = sat64(rho); mx = sat64(mx); my = sat64(my);
      if (rho != 0) begin
         ux = quot_fix(mx, rho);
         uy = quot_fix(my, rho);
      end
      uu = sat64(round_mul(ux, ux, lbc_pkg::FRACTION_BITS)
                 + round_mul(uy, uy, lbc_pkg::FRACTION_BITS));
      for (int q = 0; q < lbc_pkg::DIRS; q++) begin
         cu   = sat64(ux * cx[q] + uy * cy[q]);
         cu2  = sat64(round_mul(cu, cu, lbc_pkg::FRACTION_BITS));
         term = lbc_pkg::TWO_ONE + 6 * cu + 9 * cu2 - 3 * uu;
         wr   = round_mul(hw[(q == 0) ? 0 : (q <= 4) ? 1 : 2], rho, lbc_pkg::FRACTION_BITS);
         feq  = sat64(round_mul(wr, term, lbc_pkg::FRACTION_BITS));
         g[q] = sat64(f[q] - round_mul(longint'(om), f[q] - feq, lbc_pkg::OMEGA_FRAC));
      end
      r.g_rest       = lbc_pkg::val_type'(g[0]);
      r.g_east       = lbc_pkg::val_type'(g[1]);
      r.g_north      = lbc_pkg::val_type'(g[2]);
      r.g_west       = lbc_pkg::val_type'(g[3]);
      r.g_south      = lbc_pkg::val_type'(g[4]);
      r.g_northeast  = lbc_pkg::val_type'(g[5]);
      r.g_northwest  = lbc_pkg::val_type'(g[6]);
      r.g_southwest  = lbc_pkg::val_type'(g[7]);
      r.g_southeast  = lbc_pkg::val_type'(g[8]);
      r.node_density = lbc_pkg::val_type'(rho);
      r.velocity_x   = lbc_pkg::val_type'(ux);
      r.velocity_y   = lbc_pkg::val_type'(uy);
      return r;
   endfunction

   function automatic lbc_pkg::req_type node_all(input lbc_pkg::val_type v);
      lbc_pkg::req_type n;
      n = {lbc_pkg::DIRS{v}};
      return n;
   endfunction

   function automatic lbc_pkg::val_type rand_val(input int mode);
      case (mode)
         0: return lbc_pkg::val_type'($urandom);
         1: return lbc_pkg::val_type'($urandom_range(0, 1 << lbc_pkg::FRACTION_BITS));
         default: return lbc_pkg::val_type'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   function automatic lbc_pkg::req_type rand_node();
      lbc_pkg::req_type n;
      int mode;
      mode = $urandom_range(0, 3);
      for (int q = 0; q < lbc_pkg::DIRS; q++)
         n[q*VB +: VB] = (mode == 3) ? lbc_pkg::val_type'($urandom) : rand_val(mode);
      return n;
   endfunction

   // rsp: stall driver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            lbc_pkg::rsp_type e;
            if (collided_q.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_data);
               errors++;
            end else begin
               e = collided_q.pop_front();
               for (int k = 0; k < N_FIELDS; k++)
                  if (rsp_data[(N_FIELDS-1-k)*VB +: VB]
                      !== e[(N_FIELDS-1-k)*VB +: VB]) begin
                     $error("%s exp %h got %h", rsp_names[k],
                            e[(N_FIELDS-1-k)*VB +: VB],
                            rsp_data[(N_FIELDS-1-k)*VB +: VB]);
                     errors++;
                  end
            end
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < dst_idle_pct);
         end
      end
   end

   task automatic set_omega(input logic [OB-1:0] om);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= om;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      omega_model  = om;
   endtask

   task automatic drain();
      while (collided_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_node(input lbc_pkg::req_type n, input bit has_gold,
                            input lbc_pkg::rsp_type gold);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= n;
      collided_q.push_back(has_gold ? gold : collide(n, omega_model));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      lbc_pkg::rsp_type zero_rsp;
      lbc_pkg::rsp_type none;
      none = '0;
      zero_rsp = '0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      csr_wr_en = 1'b0; csr_wr_data = '0;
      omega_model = lbc_pkg::OMEGA_RESET;
      dir_rows[0] = '{'0, lbc_pkg::OMEGA_RESET, 1, zero_rsp};
      dir_rows[1] = '{node_all(lbc_pkg::val_type'(1 << lbc_pkg::FRACTION_BITS)),
                      lbc_pkg::OMEGA_RESET, 0, none};
      dir_rows[2] = '{node_all(lbc_pkg::val_type'(lbc_pkg::SAT_HI)),
                      lbc_pkg::OMEGA_RESET, 0, none};
      dir_rows[3] = '{node_all(lbc_pkg::val_type'(lbc_pkg::SAT_LO)),
                      lbc_pkg::OMEGA_RESET, 0, none};
      dir_rows[4] = '{lbc_pkg::req_type'({24'sd100, 24'sd1 <<< 20, {7{24'sd0}}}),
                      lbc_pkg::OMEGA_RESET, 0, none};
      dir_rows[5] = '{lbc_pkg::req_type'({24'sd0, 24'sd0, 24'sd0, 24'sd1 <<< 20,
                      {5{24'sd0}}}), OMEGA_MAX, 0, none};
      dir_rows[6] = '{lbc_pkg::req_type'({24'sd1 <<< 20, 24'h7fffff, 24'sd0, 24'h800000,
                      {5{24'sd0}}}), OMEGA_MAX, 0, none};
      dir_rows[7] = '{node_all(lbc_pkg::val_type'(12345)), '0, 0, none};
      dir_rows[8] = '{lbc_pkg::req_type'({24'sd2, {8{24'h7fffff}}}), OMEGA_ALL, 0, none};
      dir_rows[9] = '{lbc_pkg::req_type'({24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'h7fffff,
                      {4{24'sd0}}}), OMEGA_ALL, 0, none};
      dir_rows[10] = '{lbc_pkg::req_type'({24'sd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
                      24'hffffff, 24'sd0, 24'sd0, 24'sd0}), lbc_pkg::OMEGA_RESET, 0, none};
      dir_rows[11] = '{lbc_pkg::req_type'({9{24'haaaaaa}}), 22'h155555, 0, none};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (dir_rows[i].omega != omega_model) begin
            req_valid <= 1'b0;
            drain();
            set_omega(dir_rows[i].omega);
         end
         send_node(dir_rows[i].node, dir_rows[i].has_gold, dir_rows[i].gold);
      end
      req_valid <= 1'b0;
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: set_omega(lbc_pkg::OMEGA_RESET);
            1: set_omega(OMEGA_MAX);
            2: set_omega('0);
            3: set_omega(OB'($urandom_range(0, 2097152)));
            4: set_omega(OMEGA_ALL);
            default: set_omega(OB'($urandom_range(900000, 1900000)));
         endcase
         src_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 76 : 0;
         dst_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 32 : 0;
         if (ph == 4) begin
            fork
               begin
                  hold_on <= 1'b1;
                  repeat (300) @(posedge clock);
                  hold_on <= 1'b0;
               end
            join_none
         end
         for (int i = 0; i < N_RANDOM / 6; i++)
            send_node(rand_node(), 0, none);
         req_valid <= 1'b0;
      end
      drain();
      if (errors == 0)
         $display("tb_lattice_boltzmann_collision OK");
      else
         $display("tb_lattice_boltzmann_collision NOT OK");
      $finish;
   end
endmodule
